[hdl/i2cbe_pkg.sv]
// ----------------------------------------------------------------------------
// i2cbe_pkg
// Shared types and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

  localparam int unsigned TICK_W = 10;
  localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 10'd10;
  localparam int unsigned ADDR_W = 3;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_SACK  = 3'd4,
    OP_RACK  = 3'd5
  } op_t;

  // register indexes
  typedef enum logic [0:0] {
    REG_PHASE_TICKS = 1'b0
  } reg_idx_t;

  // one classified request, as queued between front and back
  typedef struct packed {
    logic       go;    // legal command offered
    op_t        op;
    logic [7:0] load;  // initial shift register contents
    logic       sda;   // sampled SDA for this tick
  } item_t;

endpackage

[hdl/i2cbe_front.sv]
// ----------------------------------------------------------------------------
// i2cbe_front
// Accepts requests, classifies the command and queues them for the engine.
// ----------------------------------------------------------------------------
module i2cbe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd_valid,
  input  logic [2:0]        operation,
  input  logic [7:0]        write_data,
  input  logic              ack_level,
  input  logic              sda_in,
  output logic              q_valid,
  output i2cbe_pkg::item_t  q_item,
  input  logic              q_pop
);
  import i2cbe_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      cls;

  always_comb begin
    cls.go   = cmd_valid && (operation <= 3'(OP_RACK));
    cls.op   = op_t'(operation);
    cls.sda  = sda_in;
    unique case (operation)
      3'(OP_WRITE): cls.load = write_data;
      3'(OP_SACK):  cls.load = {7'd0, ack_level};
      default:      cls.load = 8'd0;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != 2'd0)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count overflow");

  a_full_no_grow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 && !q_pop |=> count == 2'd2)
    else $error("full queue lost an entry");

endmodule

[hdl/i2cbe_back.sv]
// ----------------------------------------------------------------------------
// i2cbe_back
// Bus phase sequencer: steps one queued tick per cycle into the output register while not stalled.
// ----------------------------------------------------------------------------
module i2cbe_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [i2cbe_pkg::TICK_W-1:0]  phase_ticks,
  input  logic                          q_valid,
  input  i2cbe_pkg::item_t              q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          scl_out,
  output logic                          sda_out,
  output logic                          busy_res,
  output logic                          done_res,
  output logic [7:0]                    read_byte,
  output logic                          ack_bit
);
  import i2cbe_pkg::*;

  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [1:0]        phase, phase_next;
  logic [2:0]        bit_index, bit_index_next;
  op_t               cur_op, cur_op_next;
  logic [7:0]        shift_reg, shift_reg_next;
  logic              scl, scl_next;
  logic              sda, sda_next;
  logic              active, active_next;
  logic              ack_reg, ack_reg_next;
  logic [7:0]        read_hold, read_hold_next;
  logic              done;
  logic              enter;
  logic [1:0]        enter_ph;

  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    tick_count_next = tick_count;
    phase_next      = phase;
    bit_index_next  = bit_index;
    cur_op_next     = cur_op;
    shift_reg_next  = shift_reg;
    scl_next        = scl;
    sda_next        = sda;
    active_next     = active;
    ack_reg_next    = ack_reg;
    read_hold_next  = read_hold;
    done            = 1'b0;
    enter           = 1'b0;
    enter_ph        = 2'd0;

    if (active) begin
      if (tick_count != '0) begin
        tick_count_next = tick_count - 1'b1;
      end else begin
        unique case (cur_op)
          OP_START, OP_STOP, OP_SACK: begin
            if (phase == 2'd2) begin
              done = 1'b1;
            end else begin
              enter    = 1'b1;
              enter_ph = phase + 2'd1;
            end
          end
          OP_WRITE: begin
            if (phase != 2'd2) begin
              enter    = 1'b1;
              enter_ph = phase + 2'd1;
            end else if (bit_index == 3'd7) begin
              done = 1'b1;
            end else begin
              bit_index_next = bit_index + 3'd1;
              enter          = 1'b1;
              enter_ph       = 2'd0;
            end
          end
          OP_READ: begin
            if (phase == 2'd0) begin
              enter    = 1'b1;
              enter_ph = 2'd1;
            end else if (phase == 2'd1) begin
              // sample SDA while SCL is high
              shift_reg_next = {shift_reg[6:0], q_item.sda};
              enter          = 1'b1;
              enter_ph       = 2'd2;
            end else if (bit_index == 3'd7) begin
              read_hold_next = shift_reg;
              done           = 1'b1;
            end else begin
              bit_index_next = bit_index + 3'd1;
              enter          = 1'b1;
              enter_ph       = 2'd1;
            end
          end
          default: begin
            // receive ack
            if (phase == 2'd0) begin
              ack_reg_next = q_item.sda;
              enter        = 1'b1;
              enter_ph     = 2'd1;
            end else begin
              done = 1'b1;
            end
          end
        endcase
      end
      if (done) begin
        active_next = 1'b0;
      end
    end else if (q_item.go) begin
      cur_op_next    = q_item.op;
      bit_index_next = 3'd0;
      shift_reg_next = q_item.load;
      active_next    = 1'b1;
      enter          = 1'b1;
      enter_ph       = 2'd0;
    end

    if (enter) begin
      phase_next      = enter_ph;
      tick_count_next = (phase_ticks == '0) ? '0 : phase_ticks - 1'b1;
      unique case (cur_op_next)
        OP_START: begin
          if (enter_ph == 2'd0) begin
            sda_next = 1'b1;
            scl_next = 1'b1;
          end else if (enter_ph == 2'd1) begin
            sda_next = 1'b0;
          end else begin
            scl_next = 1'b0;
          end
        end
        OP_STOP: begin
          if (enter_ph == 2'd0) begin
            sda_next = 1'b0;
          end else if (enter_ph == 2'd1) begin
            scl_next = 1'b1;
          end else begin
            sda_next = 1'b1;
          end
        end
        OP_WRITE: begin
          if (enter_ph == 2'd0) begin
            sda_next = shift_reg_next[3'd7 - bit_index_next];
          end else if (enter_ph == 2'd1) begin
            scl_next = 1'b1;
          end else begin
            scl_next = 1'b0;
            // release SDA after the last bit
            if (bit_index_next == 3'd7) begin
              sda_next = 1'b1;
            end
          end
        end
        OP_READ: begin
          scl_next = (enter_ph != 2'd2);
        end
        OP_SACK: begin
          if (enter_ph == 2'd0) begin
            sda_next = shift_reg_next[0];
          end else begin
            scl_next = (enter_ph == 2'd1);
          end
        end
        default: begin
          scl_next = (enter_ph == 2'd0);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      phase      <= 2'd0;
      bit_index  <= 3'd0;
      cur_op     <= OP_START;
      shift_reg  <= 8'd0;
      scl        <= 1'b1;
      sda        <= 1'b1;
      active     <= 1'b0;
      ack_reg    <= 1'b1;
      read_hold  <= 8'd0;
    end else if (q_pop) begin
      tick_count <= tick_count_next;
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      cur_op     <= cur_op_next;
      shift_reg  <= shift_reg_next;
      scl        <= scl_next;
      sda        <= sda_next;
      active     <= active_next;
      ack_reg    <= ack_reg_next;
      read_hold  <= read_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      scl_out   <= scl_next;
      sda_out   <= sda_next;
      busy_res  <= active_next;
      done_res  <= done;
      read_byte <= read_hold_next;
      ack_bit   <= ack_reg_next;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3)
    else $error("illegal bus phase");

  a_step_fills_out: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> out_valid)
    else $error("stepped tick produced no output");

endmodule

[hdl/i2c_master_bit_engine.sv]
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master bit engine: start, stop, byte write/read and ack phase sequencing.
// ----------------------------------------------------------------------------
// Each request is one tick of the bus timing base and yields exactly one
// output with the SCL/SDA drive levels, busy, done, the last read byte and
// the last sampled ack. Requests go through a two-entry queue into the phase
// sequencer, which steps one tick per clock unless a stalled output holds
// it, so one request per cycle is sustained; the single-step sequencer
// loop and the output register set that figure. A command is taken only
// while the engine is idle; each bus phase lasts phase_ticks ticks (0
// counts as 1). phase_ticks is register 0 at byte address 0 and resets to 10.
module i2c_master_bit_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cbe_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd_valid,
  input  logic [2:0]                    operation,
  input  logic [7:0]                    write_data,
  input  logic                          ack_level,
  input  logic                          sda_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          scl_out,
  output logic                          sda_out,
  output logic                          busy_res,
  output logic                          done_res,
  output logic [7:0]                    read_byte,
  output logic                          ack_bit
);
  import i2cbe_pkg::*;

  logic [TICK_W-1:0] phase_ticks;
  logic              q_valid;
  item_t             q_item;
  logic              q_pop;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_PHASE_TICKS);
  assign prdata  = reg_sel ? {{(32-TICK_W){1'b0}}, phase_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      phase_ticks <= pwdata[TICK_W-1:0];
    end
  end

  i2cbe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd_valid  (cmd_valid),
    .operation  (operation),
    .write_data (write_data),
    .ack_level  (ack_level),
    .sda_in     (sda_in),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  i2cbe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .phase_ticks (phase_ticks),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .scl_out     (scl_out),
    .sda_out     (sda_out),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .read_byte   (read_byte),
    .ack_bit     (ack_bit)
  );

endmodule

[sim/i2c_master_bit_engine_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_tb
// Self-checking bench for the I2C master bit engine. A directed table covers
// reset levels, ignored codes, every command and the phase count extremes.
// Random bus transactions with random SDA samples follow under several phase
// counts. Each tick result is checked against fixed levels or an engine model.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;
  import i2cbe_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RUN_LEN     = 100;
  localparam logic [2:0]  OP_BAD6     = 3'd6;
  localparam logic [2:0]  OP_BAD7     = 3'd7;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rbyte;
    logic       ack;
  } bus_res_t;

  typedef struct packed {
    logic       cfg_en;
    logic [9:0] cfg_val;
    logic       cv;
    logic [2:0] op;
    logic [7:0] wd;
    logic       al;
    logic       sd;
    logic       hold;   // tick on until the command has finished
    logic       fixed;  // levels below are the expected result
    bus_res_t   levels;
  } dir_row_t;

  localparam bus_res_t RESET_LEVELS = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1};
  localparam bus_res_t START_LEVELS = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1};
  localparam bus_res_t NO_LEVELS    = '0;

  localparam op_t SCRIPT [10] = '{OP_START, OP_WRITE, OP_RACK, OP_WRITE, OP_RACK,
                                  OP_READ, OP_SACK, OP_READ, OP_SACK, OP_STOP};
  localparam logic [9:0] RUN_TICKS [5] = '{10'd1, 10'd2, 10'd3, 10'd0, 10'd1};

  dir_row_t dir_tab [19] = '{
    '{1'b0, 10'd0,    1'b0, OP_START, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, RESET_LEVELS},
    '{1'b0, 10'd0,    1'b0, OP_RACK,  8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, RESET_LEVELS},
    '{1'b0, 10'd0,    1'b1, OP_BAD6,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1, RESET_LEVELS},
    '{1'b0, 10'd0,    1'b1, OP_BAD7,  8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, RESET_LEVELS},
    '{1'b0, 10'd0,    1'b1, OP_START, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, START_LEVELS},
    '{1'b0, 10'd0,    1'b1, OP_STOP,  8'h00, 1'b0, 1'b0, 1'b1, 1'b0, NO_LEVELS},
    '{1'b1, 10'd1,    1'b1, OP_START, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, NO_LEVELS},
    '{1'b0, 10'd0,    1'b1, OP_WRITE, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, NO_LEVELS},
    '{1'b0, 10'd0,    1'b1, OP_WRITE, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, NO_LEVELS},
    '{1'b0, 10'd0,    1'b1, OP_WRITE, 8'hA5, 1'b1, 1'b1, 1'b1, 1'b0, NO_LEVELS},
    '{1'b0, 10'd0,    1'b1, OP_READ,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0, NO_LEVELS},
    '{1'b0, 10'd0,    1'b1, OP_READ,  8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, NO_LEVELS},
    '{1'b0, 10'd0,    1'b1, OP_SACK,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0, NO_LEVELS},
    '{1'b0, 10'd0,    1'b1, OP_SACK,  8'h00, 1'b1, 1'b0, 1'b1, 1'b0, NO_LEVELS},
    '{1'b0, 10'd0,    1'b1, OP_RACK,  8'h00, 1'b0, 1'b0, 1'b1, 1'b0, NO_LEVELS},
    '{1'b0, 10'd0,    1'b1, OP_RACK,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0, NO_LEVELS},
    '{1'b0, 10'd0,    1'b1, OP_STOP,  8'h00, 1'b0, 1'b0, 1'b1, 1'b0, NO_LEVELS},
    '{1'b1, 10'd0,    1'b1, OP_START, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, NO_LEVELS},
    '{1'b1, 10'd1023, 1'b0, OP_STOP,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, NO_LEVELS}
  };

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid;
  logic                in_stall;
  logic                cmd_valid;
  logic [2:0]          operation;
  logic [7:0]          write_data;
  logic                ack_level;
  logic                sda_in;
  logic                out_valid;
  logic                out_stall;
  logic                scl_out;
  logic                sda_out;
  logic                busy_res;
  logic                done_res;
  logic [7:0]          read_byte;
  logic                ack_bit;

  // engine model state
  logic [9:0] pt_cfg;
  logic [9:0] e_tick;
  logic [2:0] e_phase;
  logic [2:0] e_bit;
  op_t        e_op;
  logic [7:0] e_shift;
  logic [7:0] e_rhold;
  logic       e_scl;
  logic       e_sda;
  logic       e_active;
  logic       e_ack;

  bus_res_t    levels_due [$];
  int unsigned err_cnt;
  int unsigned quiet_cyc;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned scr_idx;
  bit          req_taken;
  bit          fix_now;
  bus_res_t    fix_levels;
  bit          hold_req;

  i2c_master_bit_engine u_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd_valid  (cmd_valid),
    .operation  (operation),
    .write_data (write_data),
    .ack_level  (ack_level),
    .sda_in     (sda_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .scl_out    (scl_out),
    .sda_out    (sda_out),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .read_byte  (read_byte),
    .ack_bit    (ack_bit)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void enter_phase(logic [2:0] ph);
    e_phase = ph;
    e_tick  = (pt_cfg == '0) ? '0 : pt_cfg - 10'd1;
    case (e_op)
      OP_START: begin
        if (ph == 3'd0) begin
          e_sda = 1'b1;
          e_scl = 1'b1;
        end else if (ph == 3'd1) e_sda = 1'b0;
        else e_scl = 1'b0;
      end
      OP_STOP: begin
        if (ph == 3'd0) e_sda = 1'b0;
        else if (ph == 3'd1) e_scl = 1'b1;
        else e_sda = 1'b1;
      end
      OP_WRITE: begin
        if (ph == 3'd0) e_sda = e_shift[3'd7 - e_bit];
        else if (ph == 3'd1) e_scl = 1'b1;
        else begin
          e_scl = 1'b0;
          if (e_bit == 3'd7) e_sda = 1'b1;
        end
      end
      OP_READ: e_scl = (ph != 3'd2);
      OP_SACK: begin
        if (ph == 3'd0) e_sda = e_shift[0];
        else if (ph == 3'd1) e_scl = 1'b1;
        else e_scl = 1'b0;
      end
      default: e_scl = (ph == 3'd0);
    endcase
  endfunction

  // close the current phase; 1 when the command sequence has finished
  function automatic logic phase_end(logic sd);
    logic fin;
    fin = 1'b0;
    case (e_op)
      OP_WRITE: begin
        if (e_phase < 3'd2) enter_phase(e_phase + 3'd1);
        else if (e_bit == 3'd7) fin = 1'b1;
        else begin
          e_bit++;
          enter_phase(3'd0);
        end
      end
      OP_READ: begin
        if (e_phase == 3'd0) enter_phase(3'd1);
        else if (e_phase == 3'd1) begin
          e_shift = {e_shift[6:0], sd};
          enter_phase(3'd2);
        end else if (e_bit == 3'd7) begin
          e_rhold = e_shift;
          fin = 1'b1;
        end else begin
          e_bit++;
          enter_phase(3'd1);
        end
      end
      OP_RACK: begin
        if (e_phase == 3'd0) begin
          e_ack = sd;
          enter_phase(3'd1);
        end else fin = 1'b1;
      end
      default: begin
        if (e_phase >= 3'd2) fin = 1'b1;
        else enter_phase(e_phase + 3'd1);
      end
    endcase
    return fin;
  endfunction

  function automatic bus_res_t bus_tick(logic cv, logic [2:0] op, logic [7:0] wd,
                                        logic al, logic sd);
    bus_res_t r;
    r = '0;
    if (e_active) begin
      if (e_tick != '0) e_tick--;
      else if (phase_end(sd)) begin
        e_active = 1'b0;
        r.done   = 1'b1;
      end
    end else if (cv && op <= OP_RACK) begin
      e_op  = op_t'(op);
      e_bit = 3'd0;
      case (e_op)
        OP_WRITE: e_shift = wd;
        OP_SACK:  e_shift = {7'd0, al};
        OP_READ:  e_shift = 8'h00;
        default:  ;
      endcase
      e_active = 1'b1;
      enter_phase(3'd0);
    end
    r.scl   = e_scl;
    r.sda   = e_sda;
    r.busy  = e_active;
    r.rbyte = e_rhold;
    r.ack   = e_ack;
    return r;
  endfunction

  task automatic check_levels(bus_res_t want, bus_res_t got);
    if (got.scl !== want.scl) begin
      $error("scl_out: expected %0d, got %0d", want.scl, got.scl);
      err_cnt++;
    end
    if (got.sda !== want.sda) begin
      $error("sda_out: expected %0d, got %0d", want.sda, got.sda);
      err_cnt++;
    end
    if (got.busy !== want.busy) begin
      $error("busy_res: expected %0d, got %0d", want.busy, got.busy);
      err_cnt++;
    end
    if (got.done !== want.done) begin
      $error("done_res: expected %0d, got %0d", want.done, got.done);
      err_cnt++;
    end
    if (got.rbyte !== want.rbyte) begin
      $error("read_byte: expected 0x%02h, got 0x%02h", want.rbyte, got.rbyte);
      err_cnt++;
    end
    if (got.ack !== want.ack) begin
      $error("ack_bit: expected %0d, got %0d", want.ack, got.ack);
      err_cnt++;
    end
  endtask

  // both handshakes in one process so a request and its result never race
  always @(posedge clk) begin
    bus_res_t got;
    bus_res_t pred;
    bit       res_taken;
    if (!rst) begin
      req_taken = in_valid && !in_stall;
      res_taken = out_valid && !out_stall;
      if (req_taken) begin
        pred = bus_tick(cmd_valid, operation, write_data, ack_level, sda_in);
        levels_due.push_back(fix_now ? fix_levels : pred);
      end
      if (res_taken) begin
        got = {scl_out, sda_out, busy_res, done_res, read_byte, ack_bit};
        if (levels_due.size() == 0) begin
          $error("result with no request waiting");
          err_cnt++;
        end else check_levels(levels_due.pop_front(), got);
      end
      quiet_cyc = (req_taken || res_taken) ? 0 : quiet_cyc + 1;
    end
  end

  initial begin
    while (quiet_cyc < QUIET_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // receiver: random stall, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  task automatic send_tick(logic cv, logic [2:0] op, logic [7:0] wd, logic al, logic sd,
                           bit fx, bus_res_t fl);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    cmd_valid  <= cv;
    operation  <= op;
    write_data <= wd;
    ack_level  <= al;
    sda_in     <= sd;
    fix_now    = fx;
    fix_levels = fl;
    do @(negedge clk); while (!req_taken);
  endtask

  task automatic random_tick(bit may_cmd);
    logic       cv;
    logic [2:0] op;
    int unsigned r;
    r  = $urandom_range(0, 99);
    op = 3'($urandom_range(0, 7));
    cv = 1'b0;
    if (may_cmd && !e_active && r < 70) begin
      cv = 1'b1;
      // mostly follow a well-formed transaction, sometimes inject noise
      if ($urandom_range(0, 9) != 0) begin
        op      = SCRIPT[scr_idx];
        scr_idx = (scr_idx + 1) % 10;
      end
    end else if (may_cmd && e_active && r < 15) cv = 1'b1;
    send_tick(cv, op, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, NO_LEVELS);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_phase_ticks(logic [9:0] val);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(REG_PHASE_TICKS));
    pwdata  <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pt_cfg = val;
    if (rd[9:0] !== val) begin
      $error("prdata: expected %0d, got %0d", val, rd[9:0]);
      err_cnt++;
    end
  endtask

  initial begin
    pt_cfg     = PHASE_TICKS_RESET;
    e_tick     = '0;
    e_phase    = 3'd0;
    e_bit      = 3'd0;
    e_op       = OP_START;
    e_shift    = 8'h00;
    e_rhold    = 8'h00;
    e_scl      = 1'b1;
    e_sda      = 1'b1;
    e_active   = 1'b0;
    e_ack      = 1'b1;
    err_cnt    = 0;
    quiet_cyc  = 0;
    scr_idx    = 0;
    req_taken  = 1'b0;
    fix_now    = 1'b0;
    fix_levels = NO_LEVELS;
    hold_req   = 1'b0;
    snd_idle_pct = 28;
    rcv_idle_pct = 49;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    cmd_valid  = 1'b0;
    operation  = OP_START;
    write_data = 8'h00;
    ack_level  = 1'b0;
    sda_in     = 1'b1;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg_en) begin
        drain_results();
        write_phase_ticks(dir_tab[i].cfg_val);
      end
      send_tick(dir_tab[i].cv, dir_tab[i].op, dir_tab[i].wd, dir_tab[i].al, dir_tab[i].sd,
                dir_tab[i].fixed, dir_tab[i].levels);
      if (dir_tab[i].hold) begin
        while (e_active)
          send_tick(1'b0, dir_tab[i].op, dir_tab[i].wd, dir_tab[i].al, dir_tab[i].sd,
                    1'b0, NO_LEVELS);
      end
    end

    for (int k = 0; k < 5; k++) begin
      drain_results();
      write_phase_ticks(RUN_TICKS[k]);
      snd_idle_pct = (k < 2) ? 28 : (k < 4) ? 49 : 0;
      rcv_idle_pct = (k < 2) ? 49 : (k < 4) ? 28 : 0;
      for (int n = 0; n < RUN_LEN; n++) begin
        // hold the receiver off while requests keep coming
        if (k == 1 && n == 40) hold_req = 1'b1;
        random_tick(1'b1);
      end
      // let the last command finish before the phase count changes
      while (e_active) random_tick(1'b0);
    end

    drain_results();
    repeat (16) @(negedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
